// ===== sv/decimating_scope_capture_macros.svh =====
// Assertion macros for the decimating scope capture checker.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef DECIMATING_SCOPE_CAPTURE_MACROS_SVH
`define DECIMATING_SCOPE_CAPTURE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DSC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dsc_pkg.sv =====
// Shared constants, field layouts and control structs of the decimating scope capture.
// No dependencies.
package dsc_pkg;

    localparam int RING_DEPTH   = 128;
    localparam int FRAME_LEN    = 256;
    localparam int CONV_RATE_HZ = 20000;
    localparam int FRAME_US     = FRAME_LEN * 1000000 / CONV_RATE_HZ;

    localparam int RAW_W    = 12;
    localparam int POS_W    = 8;
    localparam int IDX_W    = $clog2(RING_DEPTH);
    localparam int VAL_W    = 7;
    localparam int PERIOD_W = 20;
    localparam int SKIP_W   = 7;
    localparam int SKIP_MAX = 127;
    localparam int TAKE_W   = $clog2(FRAME_LEN + 1);
    localparam int DIV_W    = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // floor(p / FRAME_US) = ((p >> RATIO_SHIFT) * RATIO_MUL) >> RATIO_MUL_SHIFT for any period p
    localparam int RATIO_SHIFT     = 9;
    localparam int RATIO_DIV       = FRAME_US >> RATIO_SHIFT;
    localparam int RATIO_MUL_SHIFT = 15;
    localparam int RATIO_MUL       = ((1 << RATIO_MUL_SHIFT) + RATIO_DIV - 1) / RATIO_DIV;
    localparam int RATIO_HI_W      = PERIOD_W - RATIO_SHIFT;
    localparam int RATIO_PROD_W    = RATIO_HI_W + RATIO_MUL_SHIFT;

    localparam int SCALE_SHIFT = VAL_W - 1;
    localparam int SCALE_DIV   = (1 << RAW_W) - 1;
    localparam int SCALE_BIAS  = (1 << VAL_W) - 32;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE = 1'b1;

    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_READ    = 1'b1;
    localparam logic KIND_STORED = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam int IN_DATA_W  = 32;
    localparam int RAW_LSB    = 0;
    localparam int POS_LSB    = RAW_LSB + RAW_W;
    localparam int RIDX_LSB   = POS_LSB + POS_W;

    localparam int OUT_DATA_W   = 24;
    localparam int VAL_LSB      = 0;
    localparam int ENTRY_LSB    = VAL_LSB + VAL_W;
    localparam int NEXT_LSB     = ENTRY_LSB + IDX_W;
    localparam int OUT_USED_W   = NEXT_LSB + IDX_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                 enable;
        logic                 skip_mode;
        logic [SKIP_W-1:0]    skip;
        logic                 busy;
        logic                 clr_frames;
        logic [FRAME_LEN-1:0] keep_mask;
    } cfg_ctl_t;

    typedef struct packed {
        logic             is_read;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] index;
    } op_t;

endpackage

// ===== sv/dsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/dsc_cfg.sv =====
// Configuration registers and the sequencer that derives skip, take, stride and keep mask.
// Depends on dsc_pkg; uses one shared restoring divider for take and stride.
module dsc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [dsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dsc_pkg::PERIOD_W-1:0]    cfg_wdata,
    output dsc_pkg::cfg_ctl_t               ctl
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_TAKE   = 4'b0010,
        ST_STRIDE = 4'b0100,
        ST_FILL   = 4'b1000
    } cfg_state_t;

    cfg_state_t state_reg, state_next;
    logic enable_reg, enable_next;
    logic skip_mode_reg, skip_mode_next;
    logic [dsc_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic [dsc_pkg::FRAME_LEN-1:0] mask_reg, mask_next;
    logic [dsc_pkg::TAKE_W-1:0] take_reg, take_next;
    logic [dsc_pkg::TAKE_W-1:0] stride_reg, stride_next;
    logic [dsc_pkg::TAKE_W-1:0] acc_reg, acc_next;
    logic [dsc_pkg::TAKE_W-1:0] fill_cnt_reg, fill_cnt_next;
    logic [dsc_pkg::DIV_W-1:0] div_rem_reg, div_rem_next;
    logic [dsc_pkg::DIV_W-1:0] div_quo_reg, div_quo_next;
    logic [dsc_pkg::DIV_W-1:0] div_den_reg, div_den_next;
    logic [dsc_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [dsc_pkg::DIV_W:0]   div_shift;
    logic [dsc_pkg::DIV_W+1:0] div_trial;
    logic                      div_bit;
    logic [dsc_pkg::DIV_W-1:0] div_rem_step;
    logic [dsc_pkg::DIV_W-1:0] div_quo_step;
    logic                      div_last;
    logic [dsc_pkg::RATIO_PROD_W-1:0] ratio_prod;
    logic [dsc_pkg::RATIO_HI_W-1:0]   ratio;
    logic [dsc_pkg::RATIO_HI_W-1:0]   ratio_m1;
    logic [dsc_pkg::SKIP_W-1:0] skip_val;
    logic [dsc_pkg::TAKE_W-1:0] take_val;
    logic [dsc_pkg::PERIOD_W-1:0] period_eff;
    logic period_wr;

    assign period_wr  = cfg_we && (cfg_addr == dsc_pkg::REG_PERIOD);
    assign period_eff = (cfg_wdata == '0) ? dsc_pkg::PERIOD_W'(1) : cfg_wdata;

    assign div_shift    = {div_rem_reg, div_quo_reg[dsc_pkg::DIV_W-1]};
    assign div_trial    = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_bit      = !div_trial[dsc_pkg::DIV_W+1];
    assign div_rem_step = div_bit ? div_trial[dsc_pkg::DIV_W-1:0]
                                  : div_shift[dsc_pkg::DIV_W-1:0];
    assign div_quo_step = {div_quo_reg[dsc_pkg::DIV_W-2:0], div_bit};
    assign div_last     = (div_cnt_reg == '0);

    assign ratio_prod = dsc_pkg::RATIO_PROD_W'(period_eff[dsc_pkg::PERIOD_W-1:dsc_pkg::RATIO_SHIFT])
                        * dsc_pkg::RATIO_PROD_W'(dsc_pkg::RATIO_MUL);
    assign ratio    = ratio_prod[dsc_pkg::RATIO_PROD_W-1:dsc_pkg::RATIO_MUL_SHIFT];
    assign ratio_m1 = ratio - dsc_pkg::RATIO_HI_W'(1);
    assign skip_val = (ratio == '0) ? '0 :
                      (ratio_m1 > dsc_pkg::RATIO_HI_W'(dsc_pkg::SKIP_MAX))
                          ? dsc_pkg::SKIP_W'(dsc_pkg::SKIP_MAX)
                          : ratio_m1[dsc_pkg::SKIP_W-1:0];
    assign take_val = (div_quo_step == '0) ? dsc_pkg::TAKE_W'(1) :
                      (div_quo_step > dsc_pkg::DIV_W'(dsc_pkg::FRAME_LEN))
                          ? dsc_pkg::TAKE_W'(dsc_pkg::FRAME_LEN)
                          : div_quo_step[dsc_pkg::TAKE_W-1:0];

    always_comb begin
        state_next     = state_reg;
        enable_next    = enable_reg;
        skip_mode_next = skip_mode_reg;
        skip_next      = skip_reg;
        mask_next      = mask_reg;
        take_next      = take_reg;
        stride_next    = stride_reg;
        acc_next       = acc_reg;
        fill_cnt_next  = fill_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;

        if (cfg_we && (cfg_addr == dsc_pkg::REG_ENABLE)) begin
            enable_next = cfg_wdata[0];
        end

        if (state_reg == ST_TAKE || state_reg == ST_STRIDE) begin
            div_rem_next = div_rem_step;
            div_quo_next = div_quo_step;
            div_cnt_next = div_cnt_reg - dsc_pkg::DIV_CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                state_next = ST_IDLE;
            end
            ST_TAKE: begin
                if (div_last) begin
                    take_next    = take_val;
                    div_rem_next = '0;
                    div_quo_next = dsc_pkg::DIV_W'(dsc_pkg::FRAME_LEN);
                    div_den_next = dsc_pkg::DIV_W'(take_val);
                    div_cnt_next = dsc_pkg::DIV_CNT_W'(dsc_pkg::DIV_W - 1);
                    state_next   = ST_STRIDE;
                end
            end
            ST_STRIDE: begin
                if (div_last) begin
                    stride_next   = div_quo_step[dsc_pkg::TAKE_W-1:0];
                    mask_next     = '0;
                    acc_next      = '0;
                    fill_cnt_next = '0;
                    state_next    = ST_FILL;
                end
            end
            ST_FILL: begin
                mask_next[acc_reg[dsc_pkg::POS_W-1:0]] = 1'b1;
                acc_next      = acc_reg + stride_reg;
                fill_cnt_next = fill_cnt_reg + dsc_pkg::TAKE_W'(1);
                if (fill_cnt_reg == take_reg - dsc_pkg::TAKE_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (period_wr) begin
            skip_mode_next = period_eff > dsc_pkg::PERIOD_W'(dsc_pkg::FRAME_US);
            skip_next      = skip_val;
            div_rem_next   = '0;
            div_quo_next   = dsc_pkg::DIV_W'(dsc_pkg::FRAME_US);
            div_den_next   = period_eff;
            div_cnt_next   = dsc_pkg::DIV_CNT_W'(dsc_pkg::DIV_W - 1);
            state_next     = ST_TAKE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            skip_mode_reg <= 1'b0;
            skip_reg      <= '0;
            mask_reg      <= '1;
        end else begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            skip_mode_reg <= skip_mode_next;
            skip_reg      <= skip_next;
            mask_reg      <= mask_next;
        end
        take_reg     <= take_next;
        stride_reg   <= stride_next;
        acc_reg      <= acc_next;
        fill_cnt_reg <= fill_cnt_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_cnt_reg  <= div_cnt_next;
    end

    always_comb begin
        ctl            = '0;
        ctl.enable     = enable_reg;
        ctl.skip_mode  = skip_mode_reg;
        ctl.skip       = skip_reg;
        ctl.busy       = (state_reg != ST_IDLE);
        ctl.clr_frames = period_wr;
        ctl.keep_mask  = mask_reg;
    end

endmodule

// ===== sv/dsc_queue.sv =====
// Short operation queue between the classifying front end and the ring back end.
// Depends on dsc_pkg.
module dsc_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  dsc_pkg::op_t push_op,
    output logic         full,
    input  logic         pop,
    output dsc_pkg::op_t pop_op,
    output logic         empty
);

    dsc_pkg::op_t slot_reg [dsc_pkg::QUEUE_DEPTH];
    logic [dsc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dsc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dsc_pkg::QPTR_W:0]   count_reg, count_next;

    assign full   = (count_reg == (dsc_pkg::QPTR_W + 1)'(dsc_pkg::QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign pop_op = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + dsc_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + dsc_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (dsc_pkg::QPTR_W + 1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (dsc_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== sv/dsc_front.sv =====
// Front end: accepts input words, counts frames, selects samples and scales them.
// Depends on dsc_pkg; feeds dsc_queue.
module dsc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dsc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  dsc_pkg::cfg_ctl_t             ctl,
    input  logic                          hold,
    input  logic                          q_full,
    output logic                          q_push,
    output dsc_pkg::op_t                  q_op
);

    logic [dsc_pkg::SKIP_W-1:0] frame_cnt_reg, frame_cnt_next;

    logic [dsc_pkg::RAW_W-1:0] raw;
    logic [dsc_pkg::POS_W-1:0] pos;
    logic [dsc_pkg::IDX_W-1:0] ridx;
    logic accept, is_read, in_frame, frame_start, skip_hit, keep, counted;
    logic [dsc_pkg::RAW_W-dsc_pkg::SCALE_SHIFT-1:0] raw_hi;
    logic [dsc_pkg::RAW_W:0] low_sum;
    logic [dsc_pkg::VAL_W-1:0] quot;

    assign raw  = s_tdata[dsc_pkg::RAW_LSB +: dsc_pkg::RAW_W];
    assign pos  = s_tdata[dsc_pkg::POS_LSB +: dsc_pkg::POS_W];
    assign ridx = s_tdata[dsc_pkg::RIDX_LSB +: dsc_pkg::IDX_W];

    assign s_tready = !hold && !ctl.busy && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign is_read  = (s_tuser == dsc_pkg::ACT_READ);

    assign in_frame    = ({1'b0, pos} < dsc_pkg::TAKE_W'(dsc_pkg::FRAME_LEN));
    assign frame_start = (pos == '0);
    assign skip_hit    = (frame_cnt_reg >= ctl.skip);
    assign keep        = ctl.skip_mode ? (frame_start && skip_hit) : ctl.keep_mask[pos];
    assign counted     = accept && !is_read && ctl.enable && in_frame
                         && ctl.skip_mode && frame_start;

    // floor(x*64/4095) = hi + (lo*64 + hi >= 4095), hi = x>>6, lo = x mod 64
    assign raw_hi  = raw[dsc_pkg::RAW_W-1:dsc_pkg::SCALE_SHIFT];
    assign low_sum = {1'b0, raw[dsc_pkg::SCALE_SHIFT-1:0], dsc_pkg::SCALE_SHIFT'(0)}
                     + (dsc_pkg::RAW_W + 1)'(raw_hi);
    assign quot    = dsc_pkg::VAL_W'(raw_hi)
                     + dsc_pkg::VAL_W'(low_sum >= (dsc_pkg::RAW_W + 1)'(dsc_pkg::SCALE_DIV));

    assign q_push = accept && (is_read || (ctl.enable && in_frame && keep));

    always_comb begin
        q_op         = '0;
        q_op.is_read = is_read;
        q_op.value   = quot + dsc_pkg::VAL_W'(dsc_pkg::SCALE_BIAS);
        q_op.index   = ridx;
    end

    always_comb begin
        frame_cnt_next = frame_cnt_reg;
        if (ctl.clr_frames) begin
            frame_cnt_next = '0;
        end else if (counted) begin
            frame_cnt_next = skip_hit ? '0 : frame_cnt_reg + dsc_pkg::SKIP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_cnt_reg <= '0;
        end else begin
            frame_cnt_reg <= frame_cnt_next;
        end
    end

endmodule

// ===== sv/dsc_back.sv =====
// Back end: clears the ring after reset, writes stored samples, answers reads.
// Depends on dsc_pkg and dsc_ram; drains dsc_queue into the output register.
module dsc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_empty,
    input  dsc_pkg::op_t                   q_op,
    output logic                           q_pop,
    output logic                           clearing,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser
);

    logic clearing_reg, clearing_next;
    logic [dsc_pkg::IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [dsc_pkg::IDX_W-1:0] wp_reg, wp_next;

    logic s1_valid_reg, s1_valid_next;
    logic s1_kind_reg;
    logic [dsc_pkg::VAL_W-1:0] s1_value_reg;
    logic [dsc_pkg::IDX_W-1:0] s1_entry_reg;
    logic [dsc_pkg::IDX_W-1:0] s1_next_reg;

    logic out_valid_reg, out_valid_next;
    logic out_kind_reg;
    logic [dsc_pkg::VAL_W-1:0] out_value_reg;
    logic [dsc_pkg::IDX_W-1:0] out_entry_reg;
    logic [dsc_pkg::IDX_W-1:0] out_next_reg;

    logic s1_adv, issue;
    logic ram_we, ram_re;
    logic [dsc_pkg::IDX_W-1:0] ram_waddr;
    logic [dsc_pkg::VAL_W-1:0] ram_wdata, ram_rdata;
    logic [dsc_pkg::IDX_W-1:0] wp_inc;

    assign s1_adv = !out_valid_reg || m_tready;
    assign issue  = !clearing_reg && !q_empty && (!s1_valid_reg || s1_adv);
    assign q_pop  = issue;
    assign wp_inc = wp_reg + dsc_pkg::IDX_W'(1);

    assign ram_we    = clearing_reg || (issue && !q_op.is_read);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : wp_reg;
    assign ram_wdata = clearing_reg ? '0 : q_op.value;
    assign ram_re    = issue && q_op.is_read;

    dsc_ram #(
        .WIDTH (dsc_pkg::VAL_W),
        .DEPTH (dsc_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr   (q_op.index),
        .rd_data (ram_rdata)
    );

    always_comb begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg) begin
            clr_cnt_next = clr_cnt_reg + dsc_pkg::IDX_W'(1);
            if (clr_cnt_reg == dsc_pkg::IDX_W'(dsc_pkg::RING_DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
        wp_next = (issue && !q_op.is_read) ? wp_inc : wp_reg;
        if (issue) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_valid_reg && s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            wp_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            wp_reg        <= wp_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (issue) begin
            s1_kind_reg  <= q_op.is_read ? dsc_pkg::KIND_READ : dsc_pkg::KIND_STORED;
            s1_value_reg <= q_op.value;
            s1_entry_reg <= q_op.is_read ? q_op.index : wp_reg;
            s1_next_reg  <= q_op.is_read ? wp_reg : wp_inc;
        end
        if (s1_valid_reg && s1_adv) begin
            out_kind_reg  <= s1_kind_reg;
            out_value_reg <= (s1_kind_reg == dsc_pkg::KIND_READ) ? ram_rdata : s1_value_reg;
            out_entry_reg <= s1_entry_reg;
            out_next_reg  <= s1_next_reg;
        end
    end

    assign clearing = clearing_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {(dsc_pkg::OUT_DATA_W - dsc_pkg::OUT_USED_W)'(0),
                       out_next_reg, out_entry_reg, out_value_reg};

endmodule

// ===== sv/decimating_scope_capture.sv =====
// Decimating scope capture: converter samples in, ring store reports and read answers out.
// Input words: s_tuser = 0 for a sample, 1 for a read of ring entry read_index.
// A kept sample is scaled to floor(x*64/4095)-32, written at the write position and
// reported; every read is answered with the stored value. Results leave on the m_ channel,
// m_tuser = 0 for a stored sample, 1 for a read answer.
// Throughput: one input word per cycle while s_tready is high.
// A four-entry queue separates the front end from the ring RAM, and a registered output
// stage lets a new word enter while a result still waits: when m_tready stays low the
// queue fills and s_tready drops once six results are pending.
// After reset the ring RAM is cleared one entry per cycle, with s_tready low throughout.
// Writing sample_period_us derives the skip count at once, runs the shared divider twice
// (for take, then for stride) and then fills the keep mask one position per cycle,
// during all of which s_tready is low. Configuration writes are taken on
// any cycle; a period write restarts the derivation.
// Depends on dsc_pkg, dsc_cfg, dsc_front, dsc_queue, dsc_back and dsc_ram.
module decimating_scope_capture (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // raw_sample[11:0], frame_position[19:12], read_index[26:20], zero pad
    input  logic [dsc_pkg::IN_DATA_W-1:0]   s_tdata,
    // action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // scaled_value[6:0], entry_position[13:7], next_write_position[20:14], zero pad
    output logic [dsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    // result_kind
    output logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [dsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dsc_pkg::PERIOD_W-1:0]    cfg_wdata
);

    dsc_pkg::cfg_ctl_t ctl;
    dsc_pkg::op_t      push_op;
    dsc_pkg::op_t      pop_op;
    logic q_push, q_full, q_pop, q_empty, clearing;

    dsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl)
    );

    dsc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .ctl      (ctl),
        .hold     (clearing),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    dsc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (pop_op),
        .empty   (q_empty)
    );

    dsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_op     (pop_op),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== sv/dsc_checker.sv =====
// Port-level checks of the decimating scope capture, bound to the top level.
// Depends on dsc_pkg and decimating_scope_capture_macros.svh.
`include "decimating_scope_capture_macros.svh"

module dsc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tuser,
    input logic                            cfg_we,
    input logic [dsc_pkg::CFG_ADDR_W-1:0]  cfg_addr
);

    logic [dsc_pkg::IDX_W-1:0] out_entry;
    logic [dsc_pkg::IDX_W-1:0] out_next;

    assign out_entry = m_tdata[dsc_pkg::ENTRY_LSB +: dsc_pkg::IDX_W];
    assign out_next  = m_tdata[dsc_pkg::NEXT_LSB +: dsc_pkg::IDX_W];

    `DSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `DSC_ASSERT_IMPL(a_clear_blocks, $past(!aresetn), !s_tready,
        "input taken while ring clear runs")

    `DSC_ASSERT_NEXT(a_period_blocks, cfg_we && (cfg_addr == dsc_pkg::REG_PERIOD),
        !s_tready, "input taken while derived values are computed")

    `DSC_ASSERT_IMPL(a_store_advance, m_tvalid && (m_tuser == dsc_pkg::KIND_STORED),
        out_next == dsc_pkg::IDX_W'(out_entry + dsc_pkg::IDX_W'(1)),
        "stored result does not advance write position")

endmodule

bind decimating_scope_capture dsc_checker u_dsc_checker (.*);

// ===== tb/decimating_scope_capture_checker.sv =====
// Scoreboard for the decimating scope capture: tracks configuration writes and input
// words, models the ring store and checks every result word field by field.
// Depends on dsc_pkg.
module decimating_scope_capture_checker
    import dsc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic                   s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   m_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [PERIOD_W-1:0]    cfg_wdata,
    output int                     fail_count,
    output int                     pending_count
);

    typedef struct packed {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] entry;
        logic [IDX_W-1:0] next_wr;
    } scope_result_t;

    scope_result_t     scope_results_q[$];
    logic [VAL_W-1:0]  ring_copy [RING_DEPTH];
    logic [IDX_W-1:0]  wr_pos;
    logic [SKIP_W-1:0] frames_seen;
    logic [SKIP_W-1:0] skip_n;
    int unsigned       take_n;
    int unsigned       stride_n;
    logic              frame_skipping;
    logic              capture_on;
    int                errors;

    task automatic load_period(input logic [PERIOD_W-1:0] per);
        longint unsigned num;
        longint unsigned frm;
        longint unsigned ratio;
        longint unsigned tk;
        num = (per == '0) ? 64'd1 : 64'(per);
        num = num * 64'(CONV_RATE_HZ);
        frm = 64'(FRAME_LEN) * 64'd1000000;
        ratio = num / frm;
        tk = frm / num;
        frame_skipping = (num > frm);
        if (ratio == 0)
            skip_n = '0;
        else if (ratio - 1 > SKIP_MAX)
            skip_n = SKIP_W'(SKIP_MAX);
        else
            skip_n = SKIP_W'(ratio - 1);
        if (tk < 1)
            tk = 1;
        if (tk > FRAME_LEN)
            tk = FRAME_LEN;
        take_n = int'(tk);
        stride_n = FRAME_LEN / take_n;
        if (stride_n < 1)
            stride_n = 1;
        frames_seen = '0;
    endtask

    task automatic predict_word(input logic act, input logic [IN_DATA_W-1:0] word);
        logic [RAW_W-1:0] raw;
        logic [POS_W-1:0] pos;
        logic [IDX_W-1:0] ridx;
        scope_result_t    res;
        bit               keep;
        int               q;
        raw  = word[RAW_LSB +: RAW_W];
        pos  = word[POS_LSB +: POS_W];
        ridx = word[RIDX_LSB +: IDX_W];
        keep = 1'b0;
        if (act == ACT_READ) begin
            res.kind    = KIND_READ;
            res.value   = ring_copy[ridx];
            res.entry   = ridx;
            res.next_wr = wr_pos;
            scope_results_q.push_back(res);
        end else if (capture_on) begin
            if (frame_skipping) begin
                if (pos == '0) begin
                    if (frames_seen >= skip_n) begin
                        frames_seen = '0;
                        keep = 1'b1;
                    end else begin
                        frames_seen = frames_seen + 1'b1;
                    end
                end
            end else begin
                keep = (int'(pos) % stride_n == 0) && (int'(pos) / stride_n < take_n);
            end
            if (keep) begin
                q = (int'(raw) * 64) / 4095;
                ring_copy[wr_pos] = VAL_W'(q - 32);
                res.kind    = KIND_STORED;
                res.value   = ring_copy[wr_pos];
                res.entry   = wr_pos;
                res.next_wr = wr_pos + 1'b1;
                wr_pos      = wr_pos + 1'b1;
                scope_results_q.push_back(res);
            end
        end
    endtask

    task automatic check_word(input scope_result_t got);
        scope_result_t want;
        bit            bad;
        bad = 1'b0;
        if (scope_results_q.size() == 0) begin
            $display("%0t: unexpected result: kind %0d value %0d entry %0d next %0d", $time,
                     got.kind, $signed(got.value), got.entry, got.next_wr);
            errors++;
        end else begin
            want = scope_results_q.pop_front();
            if (got.kind !== want.kind) begin
                $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
                bad = 1'b1;
            end
            if (got.value !== want.value) begin
                $display("%0t: scaled_value expected %0d actual %0d", $time,
                         $signed(want.value), $signed(got.value));
                bad = 1'b1;
            end
            if (got.entry !== want.entry) begin
                $display("%0t: entry_position expected %0d actual %0d", $time,
                         want.entry, got.entry);
                bad = 1'b1;
            end
            if (got.next_wr !== want.next_wr) begin
                $display("%0t: next_write_position expected %0d actual %0d", $time,
                         want.next_wr, got.next_wr);
                bad = 1'b1;
            end
            if (bad)
                errors++;
        end
    endtask

    initial errors = 0;

    always @(posedge aclk) begin
        scope_result_t got;
        if (!aresetn) begin
            scope_results_q.delete();
            for (int i = 0; i < RING_DEPTH; i++)
                ring_copy[i] = '0;
            wr_pos     = '0;
            capture_on = 1'b0;
            load_period(PERIOD_W'(1));
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind    = m_tuser;
                got.value   = m_tdata[VAL_LSB +: VAL_W];
                got.entry   = m_tdata[ENTRY_LSB +: IDX_W];
                got.next_wr = m_tdata[NEXT_LSB +: IDX_W];
                check_word(got);
            end
            if (s_tvalid && s_tready)
                predict_word(s_tuser, s_tdata);
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PERIOD: load_period(cfg_wdata);
                    REG_ENABLE: capture_on = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        pending_count <= scope_results_q.size();
        fail_count    <= errors;
    end

endmodule

// ===== tb/decimating_scope_capture_tb.sv =====
// Top of the decimating scope capture testbench: clock, reset, directed and random
// word streams with random gaps on both channels, configuration phases and the verdict.
// Depends on dsc_pkg, decimating_scope_capture and decimating_scope_capture_checker.
module decimating_scope_capture_tb;
    import dsc_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_WORDS = 1700;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [PERIOD_W-1:0]   cfg_wdata;
    int                    fail_count;
    int                    pending_count;
    int                    words_sent;
    bit                    hold_req;

    decimating_scope_capture dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    decimating_scope_capture_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_period();
        case ($urandom_range(0, 9))
            0: return PERIOD_W'($urandom_range(0, 1));
            1: return PERIOD_W'($urandom_range(2, 60));
            2: return PERIOD_W'($urandom_range(61, FRAME_US));
            3: return PERIOD_W'(FRAME_US + $urandom_range(0, 1));
            4: return PERIOD_W'($urandom_range(FRAME_US + 1, 64000));
            5: return PERIOD_W'($urandom_range(64001, (1 << PERIOD_W) - 1));
            6: return $urandom_range(0, 1) ? '1 : PERIOD_W'(1000000);
            default: return PERIOD_W'($urandom_range(100, 6400));
        endcase
    endfunction

    // sink: random back-pressure, calm stretches, one long hold on request
    initial begin : sink
        int gap;
        int cyc;
        bit hold_done;
        gap = 0;
        cyc = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else begin
                m_tready <= 1'b1;
                gap = ((cyc / 1500) % 3 == 1) ? 0 : pick_gap();
            end
        end
    end

    task automatic send_word(input logic act, input logic [RAW_W-1:0] raw,
                             input logic [POS_W-1:0] pos, input logic [IDX_W-1:0] ridx);
        logic [IN_DATA_W-1:0] w;
        int gap;
        w = '0;
        w[RAW_LSB +: RAW_W]  = raw;
        w[POS_LSB +: POS_W]  = pos;
        w[RIDX_LSB +: IDX_W] = ridx;
        gap = ((words_sent / 300) % 3 == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [PERIOD_W-1:0] d);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] per, input int len,
                             input bit with_hold);
        bit               skipping;
        logic [POS_W-1:0] sweep;
        logic [RAW_W-1:0] raw;
        logic [POS_W-1:0] pos;
        logic             act;
        int               r;
        skipping = (per > FRAME_US);
        sweep = POS_W'($urandom);
        for (int i = 0; i < len; i++) begin
            if (with_hold && i == 10)
                hold_req = 1'b1;
            r = $urandom_range(0, 99);
            act = (r < 25) ? ACT_READ : ACT_SAMPLE;
            raw = RAW_W'($urandom);
            if (r >= 25 && r < 27)
                raw = '0;
            else if (r >= 27 && r < 30)
                raw = '1;
            if (skipping) begin
                pos = $urandom_range(0, 1) ? '0 : POS_W'($urandom);
            end else if ($urandom_range(0, 99) < 60) begin
                pos = sweep;
                sweep = sweep + 1'b1;
            end else begin
                pos = POS_W'($urandom);
            end
            send_word(act, raw, pos, IDX_W'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] per;
        logic                en;
        int                  len;
        int                  phase_no;
        int                  random_sent;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_SAMPLE;
        cfg_we    = 1'b0;
        cfg_addr  = REG_PERIOD;
        cfg_wdata = '0;
        words_sent = 0;
        hold_req  = 1'b0;
        phase_no  = 0;
        random_sent = 0;
        wait (aresetn);

        // capture off after reset: reads answer from the cleared ring, samples drop
        send_word(ACT_READ, '0, '0, '0);
        send_word(ACT_READ, '1, '1, '1);
        send_word(ACT_SAMPLE, '1, '0, '0);
        drain_results();
        write_reg(REG_ENABLE, PERIOD_W'(1));
        send_word(ACT_SAMPLE, '0, '0, '1);
        send_word(ACT_SAMPLE, '1, '1, '0);
        send_word(ACT_SAMPLE, RAW_W'(2047), POS_W'(128), '0);
        send_word(ACT_SAMPLE, RAW_W'(4094), POS_W'(1), '0);
        send_word(ACT_SAMPLE, RAW_W'(1), POS_W'(2), '0);
        send_word(ACT_SAMPLE, RAW_W'(64), POS_W'(3), '0);
        send_word(ACT_READ, '1, '1, '0);
        send_word(ACT_READ, '0, '0, IDX_W'(5));
        send_word(ACT_READ, '0, '0, '1);
        drain_results();
        write_reg(REG_PERIOD, '0);
        send_word(ACT_SAMPLE, RAW_W'(3000), POS_W'(77), '0);
        drain_results();
        // take below the frame length with stride one
        write_reg(REG_PERIOD, PERIOD_W'(51));
        send_word(ACT_SAMPLE, RAW_W'(1234), POS_W'(249), '0);
        send_word(ACT_SAMPLE, RAW_W'(1234), POS_W'(250), '0);
        drain_results();
        // exactly one frame time: no frame skipping, a take of one keeps position zero only
        write_reg(REG_PERIOD, PERIOD_W'(FRAME_US));
        send_word(ACT_SAMPLE, RAW_W'(100), '0, '0);
        send_word(ACT_SAMPLE, RAW_W'(100), POS_W'(128), '0);
        drain_results();
        write_reg(REG_PERIOD, PERIOD_W'(FRAME_US + 1));
        send_word(ACT_SAMPLE, RAW_W'(3500), '0, '0);
        send_word(ACT_SAMPLE, RAW_W'(3500), POS_W'(5), '0);
        drain_results();
        write_reg(REG_ENABLE, '0);
        send_word(ACT_SAMPLE, '1, '0, '0);
        send_word(ACT_READ, '0, '0, IDX_W'(9));
        drain_results();
        write_reg(REG_PERIOD, '1);
        write_reg(REG_ENABLE, PERIOD_W'(1));
        repeat (3) send_word(ACT_SAMPLE, RAW_W'($urandom), '0, '0);

        while (random_sent < RANDOM_WORDS) begin
            if (phase_no == 0) begin
                per = PERIOD_W'(1);
                en  = 1'b1;
                len = 220;
            end else begin
                per = pick_period();
                en  = ($urandom_range(0, 99) < 85);
                len = $urandom_range(60, 200);
            end
            if (len > RANDOM_WORDS - random_sent)
                len = RANDOM_WORDS - random_sent;
            drain_results();
            write_reg(REG_PERIOD, per);
            write_reg(REG_ENABLE, PERIOD_W'(en));
            run_phase(per, len, phase_no == 0);
            random_sent += len;
            phase_no++;
        end

        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("decimating_scope_capture verification clean");
        else
            $display("decimating_scope_capture verification failed");
        $finish;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("decimating_scope_capture verification failed");
        $finish;
    end

endmodule
